// ===== rtl/core/triple_des_ede_cipher_core_macros.svh =====
// Assertion macros for the triple DES core.
// No dependencies; included by files that assert.
`ifndef TRIPLE_DES_EDE_CIPHER_CORE_MACROS_SVH
`define TRIPLE_DES_EDE_CIPHER_CORE_MACROS_SVH
`ifndef SYNTH
`define TDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/tdes_pkg.sv =====
// Package for the triple DES core: DES tables, round function and types.
// No dependencies.
package tdes_pkg;
    localparam int unsigned NumRounds = 48;
    localparam int unsigned PassRounds = 16;

    typedef enum logic [1:0] {
        REG_KEY_ONE   = 2'd0,
        REG_KEY_TWO   = 2'd1,
        REG_KEY_THREE = 2'd2,
        REG_SINGLE    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        valid;
        logic [63:0] data;
    } t_stage;

    typedef logic [47:0] t_subkey;

    function automatic logic [3:0] sbox(input int unsigned n, input logic [5:0] b);
        logic [255:0] row;
        logic [5:0]   idx;
        begin
            case (n)
                0: row = 256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D;
                1: row = 256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9;
                2: row = 256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C;
                3: row = 256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E;
                4: row = 256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453;
                5: row = 256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D;
                6: row = 256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C;
                default: row = 256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B;
            endcase
            idx = {b[5], b[0], b[4:1]};
            sbox = row[255 - 4*idx -: 4];
        end
    endfunction

    // f(R, K): expand, mix key, substitute, permute.
    function automatic logic [31:0] feistel(input logic [31:0] r, input t_subkey k);
        localparam int E [48] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
            16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
        localparam int P [32] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
            2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] o;
        begin
            for (int i = 0; i < 48; i++) x[47-i] = r[32-E[i]];
            x = x ^ k;
            for (int j = 0; j < 8; j++) s[31-4*j -: 4] = sbox(j, x[47-6*j -: 6]);
            for (int i = 0; i < 32; i++) o[31-i] = s[32-P[i]];
            feistel = o;
        end
    endfunction

    function automatic logic [63:0] ip(input logic [63:0] x);
        localparam int T [64] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
            62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,
            59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
        logic [63:0] o;
        begin
            for (int i = 0; i < 64; i++) o[63-i] = x[64-T[i]];
            ip = o;
        end
    endfunction

    function automatic logic [63:0] fp(input logic [63:0] x);
        localparam int T [64] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
            38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,
            35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
        logic [63:0] o;
        begin
            for (int i = 0; i < 64; i++) o[63-i] = x[64-T[i]];
            fp = o;
        end
    endfunction

    // Subkey for round i (0..15) of one key.
    function automatic t_subkey subkey(input logic [63:0] key, input int unsigned i);
        localparam int PC1 [56] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,
            10,2,59,51,43,35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,
            7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
        localparam int PC2 [48] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,
            16,7,27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,
            46,42,50,36,29,32};
        localparam int ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        t_subkey     o;
        begin
            for (int k = 0; k < 56; k++) cd[55-k] = key[64-PC1[k]];
            c = cd[55:28];
            d = cd[27:0];
            for (int k = 0; k < 16; k++) begin
                if (k <= int'(i)) begin
                    for (int s = 0; s < ROT[k]; s++) begin
                        c = {c[26:0], c[27]};
                        d = {d[26:0], d[27]};
                    end
                end
            end
            cd = {c, d};
            for (int k = 0; k < 48; k++) o[47-k] = cd[56-PC2[k]];
            subkey = o;
        end
    endfunction
endpackage

// ===== rtl/core/tdes_keysched.sv =====
// Key schedule: registers the 16 subkeys of one key.
// Depends on tdes_pkg.
module tdes_keysched (
    input  logic                   i_clk,
    input  logic [63:0]            i_key,
    output tdes_pkg::t_subkey      o_sk [16]
);
    import tdes_pkg::*;

    // The user must change keys only while idle, which the block does not enforce; subkeys are registered from i_key.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) o_sk[i] <= subkey(i_key, i);
    end
endmodule

// ===== rtl/core/tdes_round.sv =====
// One Feistel round stage with valid bit and control sideband.
// Depends on tdes_pkg.
module tdes_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdes_pkg::t_stage  i_stage,
    input  logic [1:0]        i_ctl,
    input  tdes_pkg::t_subkey i_sk,
    input  logic              i_bypass,
    output tdes_pkg::t_stage  o_stage,
    output logic [1:0]        o_ctl
);
    import tdes_pkg::*;

    logic [63:0] n_data;

    always_comb begin
        if (i_bypass) begin
            n_data = i_stage.data;
        end else begin
            n_data = {i_stage.data[31:0],
                      i_stage.data[63:32] ^ feistel(i_stage.data[31:0], i_sk)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_stage.valid <= 1'b0;
        end else begin
            o_stage.valid <= i_stage.valid;
        end
        o_stage.data <= n_data;
        o_ctl        <= i_ctl;
    end
endmodule

// ===== rtl/core/triple_des_ede_cipher_core.sv =====
// Triple DES EDE core, one 64-bit word per cycle, fully pipelined over 48 rounds.
// Pipeline from start to o_valid: input register, 48 round stages, output register.
// Throughput: one word every cycle; start is taken whenever busy is low.
// busy is tied low: the receiver cannot stall, so nothing ever backs up.
// Reset (synchronous, active low) clears keys, mode and all valid bits.
// Subkeys are registered from the key registers: a key write passes the key register, then the subkey register.
`include "triple_des_ede_cipher_core_macros.svh"
module triple_des_ede_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [63:0] i_data_block,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [63:0] o_result_block
);
    import tdes_pkg::*;

    logic [63:0] r_key_one, r_key_two, r_key_three;
    logic        r_single;
    t_subkey     sk1 [16], sk2 [16], sk3 [16];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_one   <= '0;
            r_key_two   <= '0;
            r_key_three <= '0;
            r_single    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY_ONE:   r_key_one   <= i_cfg_data;
                REG_KEY_TWO:   r_key_two   <= i_cfg_data;
                REG_KEY_THREE: r_key_three <= i_cfg_data;
                REG_SINGLE:    r_single    <= i_cfg_data[0];
                default:       r_single    <= r_single;
            endcase
        end
    end

    tdes_keysched u_ks1 (.i_clk(i_clk), .i_key(r_key_one),   .o_sk(sk1));
    tdes_keysched u_ks2 (.i_clk(i_clk), .i_key(r_key_two),   .o_sk(sk2));
    tdes_keysched u_ks3 (.i_clk(i_clk), .i_key(r_key_three), .o_sk(sk3));

    assign busy = 1'b0;

    // Stage 0: capture word, apply IP; ctl = {single, decrypt}.
    t_stage     st  [NumRounds+1];
    logic [1:0] ctl [NumRounds+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            st[0].valid <= 1'b0;
        end else begin
            st[0].valid <= start && !busy;
        end
        st[0].data <= ip(i_data_block);
        ctl[0]     <= {r_single, i_op};
    end

    // Round g of pass p. Between passes FP then IP cancel, but the half swap
    // at a pass end must be undone; apply it at each pass start.
    for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
        localparam int P = g / PassRounds;
        localparam int R = g % PassRounds;
        t_subkey sk;
        t_stage  in_st;
        logic    dec_pass;
        logic    byp;

        always_comb begin
            // Pass decrypt flag: enc EDE = E,D,E; dec = D,E,D; single = op.
            dec_pass = (P == 1) ? !ctl[g][0] : ctl[g][0];
            if (ctl[g][1]) begin
                sk = dec_pass ? sk1[PassRounds-1-R] : sk1[R];
            end else if (P == 1) begin
                sk = dec_pass ? sk2[PassRounds-1-R] : sk2[R];
            end else if ((P == 0) != ctl[g][0]) begin
                sk = dec_pass ? sk1[PassRounds-1-R] : sk1[R];
            end else begin
                sk = dec_pass ? sk3[PassRounds-1-R] : sk3[R];
            end
            byp   = ctl[g][1] && (P != 0);
            in_st = st[g];
            // Swap halves at the start of passes two and three (triple mode only).
            if (R == 0 && P != 0 && !ctl[g][1]) begin
                in_st.data = {st[g].data[31:0], st[g].data[63:32]};
            end
        end

        tdes_round u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (in_st),
            .i_ctl   (ctl[g]),
            .i_sk    (sk),
            .i_bypass(byp),
            .o_stage (st[g+1]),
            .o_ctl   (ctl[g+1])
        );
    end

    // Output: swap halves, FP. Single mode words bypassed passes two and three.
    logic r_valid;
    logic [63:0] r_result;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= st[NumRounds].valid;
        end
        r_result <= fp({st[NumRounds].data[31:0], st[NumRounds].data[63:32]});
    end

    assign o_valid        = r_valid;
    assign o_result_block = r_result;

    `TDC_ASSERT_NEXT(a_in_flows, i_clk, i_rst_n, start, st[0].valid)
    `TDC_ASSERT_NEXT(a_out_from_pipe, i_clk, i_rst_n, st[NumRounds].valid, o_valid)
    `TDC_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
endmodule
